FILE: hw/rtl/pfsr_pkg.sv
// ----------------------------------------------------------------------------
// Polyline resampler package
// Widths, defaults and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsr_pkg;

    localparam int COORD_W         = 32;
    localparam int SPACING_W       = 31;
    localparam int OWED_W          = 31;
    localparam int LEN_W           = 34;
    localparam int ARC_W           = 35;
    localparam int ITER_W          = 6;
    localparam int SQRT_STEPS      = 34;
    localparam int DIV_STEPS       = 32;
    localparam int MAX_SAMPLES_DEF = 63;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd6554;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQRT,
        OP_SEG_INIT,
        OP_MUL,
        OP_NUM,
        OP_DIV,
        OP_EMIT_VTX,
        OP_EMIT_SMP,
        OP_EMIT_APP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis_y;
    } t_cmd;

    typedef struct packed {
        logic new_path;
        logic len_zero;
        logic more;
        logic iter_done;
        logic out_free;
        logic need_append;
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/pfsr_if.sv
// ----------------------------------------------------------------------------
// Polyline resampler channels
// Vertex input, sample output and spacing configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfsr_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               first_vertex;
    logic               last_vertex;

    modport source (output valid, output vertex_x, output vertex_y,
                    output first_vertex, output last_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y,
                    input first_vertex, input last_vertex, output ready);
endinterface

interface pfsr_smp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic               run_last;
    logic               path_end;
    logic               truncated;

    modport source (output valid, output sample_x, output sample_y, output run_last,
                    output path_end, output truncated, input ready);
    modport sink   (input valid, input sample_x, input sample_y, input run_last,
                    input path_end, input truncated, output ready);
endinterface

interface pfsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pfsr_ctrl.sv
// ----------------------------------------------------------------------------
// Polyline resampler controller
// Sequences one vertex through length, interpolation and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pfsr_pkg::t_status i_status,
    output pfsr_pkg::t_cmd    o_cmd
);
    import pfsr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_START = 13'b0000000000010,
        S_VTX   = 13'b0000000000100,
        S_SQY   = 13'b0000000001000,
        S_SQRT  = 13'b0000000010000,
        S_INIT  = 13'b0000000100000,
        S_TEST  = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_NUM   = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_EMIT  = 13'b0010000000000,
        S_APP   = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_axis       = r_axis;
        o_cmd.op     = OP_NONE;
        o_cmd.axis_y = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_status.new_path) begin
                    n_state = S_VTX;
                end else begin
                    o_cmd.op = OP_SQ_X;
                    n_state  = S_SQY;
                end
            end
            S_VTX: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_VTX;
                    n_state  = S_IDLE;
                end
            end
            S_SQY: begin
                o_cmd.op = OP_SQ_Y;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.iter_done) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_SEG_INIT;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (!i_status.len_zero && i_status.more) begin
                    n_axis  = 1'b0;
                    n_state = S_MUL;
                end else begin
                    n_state = S_APP;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.iter_done) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_SMP;
                    n_state  = S_TEST;
                end
            end
            S_APP: begin
                if (!i_status.need_append) begin
                    n_state = S_FIN;
                end else if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_APP;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A new vertex is only taken from the idle state.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |-> (r_state == S_IDLE))
        else $error("load outside idle");

    // Every finished length computation is followed by the segment setup.
    a_sqrt_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && i_status.iter_done) |=> (r_state == S_INIT))
        else $error("sqrt not followed by setup");

    // The y division always follows an x division for the same sample.
    a_axis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_axis)
        else $error("emit before both axes");

endmodule

`default_nettype wire

FILE: hw/rtl/pfsr_dp.sv
// ----------------------------------------------------------------------------
// Polyline resampler datapath
// Vertex state, segment length root, interpolation divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsr_dp #(
    parameter int MAX_SEGMENT_SAMPLES = pfsr_pkg::MAX_SAMPLES_DEF,
    parameter int FRACTION_BITS       = pfsr_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic               i_first_vertex,
    input  logic               i_last_vertex,
    input  pfsr_pkg::t_cmd     i_cmd,
    output pfsr_pkg::t_status  o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_sample_x,
    output logic signed [31:0] o_sample_y,
    output logic               o_run_last,
    output logic               o_path_end,
    output logic               o_truncated
);
    import pfsr_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENT_SAMPLES + 1);
    localparam logic [SPACING_W-1:0] MIN_SPACING =
        SPACING_W'(((64'd1 << FRACTION_BITS) + 64'd999) / 64'd1000);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENT_SAMPLES);

    logic [SPACING_W-1:0] r_spacing, r_eff;
    logic [COORD_W-1:0]   r_x, r_y, r_prev_x, r_prev_y, r_em_x, r_em_y;
    logic                 r_last, r_new, r_inside;
    logic [COORD_W-1:0]   r_ax, r_ay;
    logic                 r_sx, r_sy;
    logic [OWED_W-1:0]    r_owed;
    logic [63:0]          r_sq;
    logic [67:0]          r_rad;
    logic [LEN_W-1:0]     r_root;
    logic [35:0]          r_srem;
    logic [ITER_W-1:0]    r_iter;
    logic [ARC_W-1:0]     r_s;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_trunc;
    logic [63:0]          r_plo;
    logic [33:0]          r_phi;
    logic [34:0]          r_drem;
    logic [31:0]          r_dlo, r_quo, r_offx;
    logic                 r_out_valid;

    logic [32:0] dx, dy;
    logic [SPACING_W-1:0] eff_in;
    logic [37:0] sq_t, sq_trial;
    logic        sq_ge;
    logic [35:0] dv_t;
    logic        dv_ge;
    logic [31:0] mag;
    logic [33:0] phi;
    logic [66:0] num;
    logic [37:0] limit;
    logic [COORD_W-1:0] pt_x, pt_y;
    logic [ARC_W-1:0]   s_next, s_diff;
    logic        more_next, pt_differs, smp_run_last, out_free;
    logic [63:0] sq_y;
    logic [64:0] sum;
    logic        emit_op;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit_op  = (i_cmd.op == OP_EMIT_VTX) || (i_cmd.op == OP_EMIT_SMP)
                   || (i_cmd.op == OP_EMIT_APP);

    assign dx = {i_vertex_x[31], i_vertex_x} - {r_prev_x[31], r_prev_x};
    assign dy = {i_vertex_y[31], i_vertex_y} - {r_prev_y[31], r_prev_y};
    assign eff_in = (r_spacing < MIN_SPACING) ? MIN_SPACING : r_spacing;

    assign sq_y = r_ay * r_ay;
    assign sum  = {1'b0, r_sq} + {1'b0, sq_y};

    // One root bit per step, taken from two radicand bits.
    assign sq_t     = {r_srem, r_rad[67:66]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    // One quotient bit of the interpolation offset per step.
    assign dv_t  = {r_drem, r_dlo[31]};
    assign dv_ge = (dv_t >= {2'b00, r_root});

    assign mag = i_cmd.axis_y ? r_ay : r_ax;
    assign phi = (r_s[32] ? {2'b00, mag} : 34'd0) + (r_s[33] ? {1'b0, mag, 1'b0} : 34'd0);
    assign num = {1'b0, r_phi, 32'd0} + {3'b000, r_plo} + {34'd0, r_root[LEN_W-1:1]};

    assign limit = {7'd0, r_owed} + 38'(r_eff) * 38'(MAX_SEGMENT_SAMPLES);

    assign pt_x = r_sx ? (r_prev_x - r_offx) : (r_prev_x + r_offx);
    assign pt_y = r_sy ? (r_prev_y - r_quo) : (r_prev_y + r_quo);

    assign s_next    = r_s + {4'd0, r_eff};
    assign s_diff    = r_s - {1'b0, r_root};
    assign more_next = (s_next < {1'b0, r_root}) && ((r_cnt + 1'b1) < CNT_MAX);
    assign pt_differs   = (pt_x != r_x) || (pt_y != r_y);
    assign smp_run_last = !more_next && !(r_last && pt_differs);

    assign o_status.new_path    = r_new;
    assign o_status.len_zero    = (r_root == '0);
    assign o_status.more        = (r_s < {1'b0, r_root}) && (r_cnt < CNT_MAX);
    assign o_status.iter_done   = (r_iter == '0);
    assign o_status.out_free    = out_free;
    assign o_status.need_append = r_last && ((r_em_x != r_x) || (r_em_y != r_y));

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= SPACING_RESET;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_em_x      <= '0;
            r_em_y      <= '0;
            r_owed      <= '0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_spacing <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && !emit_op) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_NONE: begin
                end
                OP_LOAD: begin
                    r_x    <= i_vertex_x;
                    r_y    <= i_vertex_y;
                    r_last <= i_last_vertex;
                    r_new  <= i_first_vertex || !r_inside;
                    r_ax   <= dx[32] ? 32'(-dx) : dx[31:0];
                    r_ay   <= dy[32] ? 32'(-dy) : dy[31:0];
                    r_sx   <= dx[32];
                    r_sy   <= dy[32];
                    r_eff  <= eff_in;
                end
                OP_SQ_X: begin
                    r_sq <= r_ax * r_ax;
                end
                OP_SQ_Y: begin
                    r_rad  <= {3'b000, sum};
                    r_root <= '0;
                    r_srem <= '0;
                    r_iter <= ITER_W'(SQRT_STEPS - 1);
                end
                OP_SQRT: begin
                    r_rad <= {r_rad[65:0], 2'b00};
                    if (sq_ge) begin
                        r_srem <= 36'(sq_t - sq_trial);
                        r_root <= {r_root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_srem <= sq_t[35:0];
                        r_root <= {r_root[LEN_W-2:0], 1'b0};
                    end
                    r_iter <= r_iter - 1'b1;
                end
                OP_SEG_INIT: begin
                    r_s     <= {4'd0, r_owed};
                    r_cnt   <= '0;
                    r_trunc <= (r_root != '0) && (limit < {4'd0, r_root});
                end
                OP_MUL: begin
                    r_plo <= r_s[31:0] * mag;
                    r_phi <= phi;
                    if (i_cmd.axis_y) begin
                        r_offx <= r_quo;
                    end
                end
                OP_NUM: begin
                    r_drem <= num[66:32];
                    r_dlo  <= num[31:0];
                    r_quo  <= '0;
                    r_iter <= ITER_W'(DIV_STEPS - 1);
                end
                OP_DIV: begin
                    r_drem <= dv_ge ? 35'(dv_t - {2'b00, r_root}) : dv_t[34:0];
                    r_dlo  <= {r_dlo[30:0], 1'b0};
                    r_quo  <= {r_quo[30:0], dv_ge};
                    r_iter <= r_iter - 1'b1;
                end
                OP_EMIT_VTX: begin
                    r_out_valid <= 1'b1;
                    o_sample_x  <= r_x;
                    o_sample_y  <= r_y;
                    o_run_last  <= 1'b1;
                    o_path_end  <= r_last;
                    o_truncated <= 1'b0;
                    r_em_x      <= r_x;
                    r_em_y      <= r_y;
                    r_owed      <= r_eff;
                    r_prev_x    <= r_x;
                    r_prev_y    <= r_y;
                    r_inside    <= !r_last;
                end
                OP_EMIT_SMP: begin
                    r_out_valid <= 1'b1;
                    o_sample_x  <= pt_x;
                    o_sample_y  <= pt_y;
                    o_run_last  <= smp_run_last;
                    o_path_end  <= smp_run_last && r_last;
                    o_truncated <= r_trunc;
                    r_em_x      <= pt_x;
                    r_em_y      <= pt_y;
                    r_s         <= s_next;
                    r_cnt       <= r_cnt + 1'b1;
                end
                OP_EMIT_APP: begin
                    r_out_valid <= 1'b1;
                    o_sample_x  <= r_x;
                    o_sample_y  <= r_y;
                    o_run_last  <= 1'b1;
                    o_path_end  <= 1'b1;
                    o_truncated <= r_trunc;
                    r_em_x      <= r_x;
                    r_em_y      <= r_y;
                end
                OP_FINISH: begin
                    // A zero-length segment leaves the owed distance alone.
                    if (r_root != '0) begin
                        if (r_trunc || s_diff == '0) begin
                            r_owed <= r_eff;
                        end else begin
                            r_owed <= s_diff[OWED_W-1:0];
                        end
                    end
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                    r_inside <= !r_last;
                end
                default: begin
                end
            endcase
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT_VTX || i_cmd.op == OP_EMIT_SMP || i_cmd.op == OP_EMIT_APP)
        |-> out_free)
        else $error("result overwrites a pending transfer");

    a_smp_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT_SMP) |-> (r_s < {1'b0, r_root}) && (r_cnt < CNT_MAX))
        else $error("sample beyond segment or cap");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV && r_iter != '0) |=> (r_iter == $past(r_iter) - 1'b1))
        else $error("divider step count broken");

endmodule

`default_nettype wire

FILE: hw/rtl/polyline_fixed_spacing_resampler.sv
// A path's first vertex is loaded, then passes the start and vertex states to the output
// register; the vertex state waits while the output is busy. A following vertex gets its
// segment length from a 34-step square root, then each sample from one 32-step divider run
// for x then y. One vertex at a time; a new one is taken while a result waits at the output.
// Reset (synchronous, active low) closes any open path and sets the spacing to 6554.
// ----------------------------------------------------------------------------
// Polyline fixed-spacing resampler
// Emits points evenly spaced along the arc length of a vertex stream.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_fixed_spacing_resampler #(
    parameter int MAX_SEGMENT_SAMPLES = pfsr_pkg::MAX_SAMPLES_DEF,
    parameter int FRACTION_BITS       = pfsr_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfsr_cfg_if.sink    i_cfg,
    pfsr_vtx_if.sink    i_vtx,
    pfsr_smp_if.source  o_smp
);
    import pfsr_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_vtx.ready = in_ready;

    pfsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfsr_dp #(
        .MAX_SEGMENT_SAMPLES (MAX_SEGMENT_SAMPLES),
        .FRACTION_BITS       (FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .i_vertex_x     (i_vtx.vertex_x),
        .i_vertex_y     (i_vtx.vertex_y),
        .i_first_vertex (i_vtx.first_vertex),
        .i_last_vertex  (i_vtx.last_vertex),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_smp.valid),
        .i_out_ready    (o_smp.ready),
        .o_sample_x     (o_smp.sample_x),
        .o_sample_y     (o_smp.sample_y),
        .o_run_last     (o_smp.run_last),
        .o_path_end     (o_smp.path_end),
        .o_truncated    (o_smp.truncated)
    );

endmodule

`default_nettype wire

FILE: tb/pfsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline resampler checker
// Watches the vertex, sample and spacing channels, predicts the samples that
// each vertex transfer produces and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsr_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pfsr_cfg_if     cfg,
    pfsr_vtx_if     vtx,
    pfsr_smp_if     smp,
    output int      o_fail_count,
    output int      o_pending
);
    import pfsr_pkg::*;

    localparam longint MIN_SPACING = 66;
    localparam int     SEG_CAP     = 63;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               run_last;
        logic               path_end;
        logic               truncated;
    } t_sample;

    t_sample sample_q[$];

    logic [SPACING_W-1:0] spacing;
    longint prev_x, prev_y, owed, emit_x, emit_y;
    bit     in_path;
    int     mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = sample_q.size();

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    // Rounded position along one axis; the product can exceed 64 bits.
    function automatic longint lerp(longint start, longint delta,
                                    longint unsigned s, longint unsigned len);
        logic [127:0] num;
        logic [127:0] off;
        longint unsigned mag;
        mag = (delta < 0) ? -delta : delta;
        num = 128'(s) * 128'(mag) + 128'(len >> 1);
        off = num / 128'(len);
        return (delta < 0) ? start - longint'(off[63:0]) : start + longint'(off[63:0]);
    endfunction

    task automatic predict_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                  bit first, bit last);
        t_sample run[$];
        t_sample smp_item;
        longint  x, y, dx, dy, eff;
        longint unsigned ax, ay, len, s;
        bit      trunc;
        int      cnt;
        x = vx;
        y = vy;
        eff = (spacing < MIN_SPACING) ? MIN_SPACING : spacing;
        trunc = 0;
        smp_item = '0;
        if (first || !in_path) begin
            smp_item.x = 32'(x); smp_item.y = 32'(y); run = {run, smp_item};
            emit_x = x; emit_y = y;
            owed = eff;
            in_path = 1;
        end else begin
            dx = x - prev_x;
            dy = y - prev_y;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            // Sum of squares fits in 65 bits; the square root fits in 33.
            begin
                logic [64:0] sum;
                logic [127:0] r;
                sum = 65'(ax) * 65'(ax) + 65'(ay) * 65'(ay);
                if (sum[64]) begin
                    len = 0;
                    for (int b = 33; b >= 0; b--) begin
                        r = 128'(len | (64'd1 << b));
                        if (r * r <= 128'(sum)) len = len | (64'd1 << b);
                    end
                end else begin
                    len = isqrt64(sum[63:0]);
                end
            end
            if (len != 0) begin
                s = owed;
                cnt = 0;
                while (s < len && cnt < SEG_CAP) begin
                    smp_item.x = 32'(lerp(prev_x, dx, s, len));
                    smp_item.y = 32'(lerp(prev_y, dy, s, len));
                    run = {run, smp_item};
                    emit_x = longint'(smp_item.x);
                    emit_y = longint'(smp_item.y);
                    s += eff;
                    cnt++;
                end
                if (s < len) begin
                    trunc = 1;
                    owed = eff;
                end else begin
                    owed = s - len;
                    if (owed == 0) owed = eff;
                end
            end
            if (last && (emit_x != x || emit_y != y)) begin
                smp_item.x = 32'(x); smp_item.y = 32'(y); run = {run, smp_item};
                emit_x = x; emit_y = y;
            end
        end
        prev_x = x;
        prev_y = y;
        if (last) in_path = 0;
        foreach (run[i]) begin
            run[i].truncated = trunc;
            run[i].run_last  = (i == run.size() - 1);
            run[i].path_end  = (i == run.size() - 1) && last;
            sample_q = {sample_q, run[i]};
        end
    endtask

    task automatic report(string what, t_sample exp_s, t_sample got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t sample mismatch (%s): expected x=%h y=%h rl=%b pe=%b tr=%b,",
                      " got x=%h y=%h rl=%b pe=%b tr=%b"},
                     $time, what, exp_s.x, exp_s.y, exp_s.run_last, exp_s.path_end,
                     exp_s.truncated, got.x, got.y, got.run_last, got.path_end,
                     got.truncated);
    endtask

    always @(posedge i_clk) begin
        t_sample got;
        t_sample exp_s;
        if (!i_rst_n) begin
            spacing <= SPACING_RESET;
            prev_x = 0; prev_y = 0; owed = 0; emit_x = 0; emit_y = 0; in_path = 0;
            sample_q.delete();
            mismatches = 0;
        end else begin
            if (smp.valid && smp.ready) begin
                got.x = smp.sample_x;
                got.y = smp.sample_y;
                got.run_last = smp.run_last;
                got.path_end = smp.path_end;
                got.truncated = smp.truncated;
                if (sample_q.size() == 0) begin
                    report("no sample expected", '0, got);
                end else begin
                    exp_s = sample_q.pop_front();
                    if (got !== exp_s) report("field differs", exp_s, got);
                end
            end
            if (vtx.valid && vtx.ready)
                predict_vertex(vtx.vertex_x, vtx.vertex_y, vtx.first_vertex,
                               vtx.last_vertex);
            if (cfg.valid && cfg.ready) spacing <= cfg.data;
        end
    end
endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline resampler testbench
// Drives directed and random vertex paths under several spacings with random
// gaps and output stalls; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pfsr_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off;

    pfsr_cfg_if cfg ();
    pfsr_vtx_if vtx ();
    pfsr_smp_if smp ();

    polyline_fixed_spacing_resampler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg.sink),
        .i_vtx   (vtx.sink),
        .o_smp   (smp.source)
    );

    pfsr_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg          (cfg),
        .vtx          (vtx),
        .smp          (smp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("polyline_fixed_spacing_resampler verification failed");
        $finish;
    end

    // Receiver: random stall per sample, plus one long hold-off on request.
    initial begin
        int wait_cycles;
        bit held;
        smp.ready = 0;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !held) begin
                smp.ready <= 0;
                repeat (600) @(posedge i_clk);
                held = 1;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0) begin
                smp.ready <= 0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            smp.ready <= 1;
            @(posedge i_clk);
            while (!smp.valid) @(posedge i_clk);
        end
    end

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               bit first, bit last, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            vtx.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid <= 1;
        vtx.vertex_x <= x;
        vtx.vertex_y <= y;
        vtx.first_vertex <= first;
        vtx.last_vertex <= last;
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        vtx.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_spacing(logic [30:0] value);
        cfg.valid <= 1;
        cfg.data <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    // A well-formed path; coordinates stay near the step so sample counts stay low.
    task automatic random_path(int unsigned step, int n);
        logic signed [31:0] x, y;
        bit                 fast;
        x = $urandom;
        y = $urandom;
        fast = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                x = x + $signed($urandom_range(0, 2 * step)) - $signed(step);
                y = y + $signed($urandom_range(0, 2 * step)) - $signed(step);
                if ($urandom_range(0, 9) == 0) begin
                    x = x;
                end
            end
            send_vertex(x, y, i == 0, i == n - 1, fast);
        end
    endtask

    initial begin
        logic [30:0] spacings[5];
        vtx.valid = 0; vtx.vertex_x = 0; vtx.vertex_y = 0;
        vtx.first_vertex = 0; vtx.last_vertex = 0;
        cfg.valid = 0; cfg.data = 0;
        hold_off = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset spacing, extremes, zero-length, duplicate last, first+last.
        send_vertex(32'sh7fffffff, 32'sh80000000, 1, 1, 0);
        send_vertex(0, 0, 0, 0, 0);                // no open path: acts as first
        send_vertex(0, 0, 0, 0, 0);                // zero-length segment
        send_vertex(32'sh00010000, 0, 0, 0, 0);
        send_vertex(32'sh00010000, 32'sh00008000, 0, 1, 0);
        send_vertex(5, 5, 1, 0, 0);
        send_vertex(9, 9, 1, 0, 0);                // first while open: drops the path
        send_vertex(9, 9, 0, 1, 0);                // last equals emitted point
        drain();
        write_spacing(0);                          // clamped to minimum
        send_vertex(0, 0, 1, 0, 0);
        send_vertex(32'sh00002000, -32'sh00001000, 0, 0, 0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);   // hits the cap
        send_vertex(32'sh80000000, 32'sh80000000, 0, 0, 0);   // widest segment
        send_vertex(-32'sh100, 32'sh100, 0, 1, 0);
        drain();
        write_spacing(31'h7fffffff);
        send_vertex(32'sh80000000, 32'sh7fffffff, 1, 0, 0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 0, 0, 0);
        send_vertex(-32'sh1, 32'sh1, 0, 1, 0);
        drain();

        // Random paths under several spacings.
        spacings = '{31'd66, 31'd6554, 31'd65536, 31'd1000, 31'd300000};
        foreach (spacings[k]) begin
            write_spacing(spacings[k]);
            for (int p = 0; p < 9; p++) begin
                int n;
                n = $urandom_range(1, 8);
                if (k == 1 && p == 3) hold_off = 1;
                if ($urandom_range(0, 7) == 0)
                    send_vertex($urandom, $urandom, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 0);
                random_path(spacings[k] * $urandom_range(1, 4), n);
            end
            drain();
        end
        write_spacing(SPACING_RESET);

        if (fail_count == 0) begin
            $display("polyline_fixed_spacing_resampler verification clean");
        end else begin
            $display("polyline_fixed_spacing_resampler verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
